// ----- src/ntfc_pkg.sv -----
// Shared types and constants for the nearest-target follow controller.
package ntfc_pkg;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_MODE  = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [1:0] ST_CHOSEN  = 2'd0;
    localparam logic [1:0] ST_CMD     = 2'd1;
    localparam logic [1:0] ST_LOST    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [2:0] REG_FOLLOW = 3'd0;
    localparam logic [2:0] REG_LDB    = 3'd1;
    localparam logic [2:0] REG_ADB    = 3'd2;
    localparam logic [2:0] REG_LGAIN  = 3'd3;
    localparam logic [2:0] REG_AGAIN  = 3'd4;
    localparam logic [2:0] REG_LMAX   = 3'd5;
    localparam logic [2:0] REG_LMIN   = 3'd6;
    localparam logic [2:0] REG_AMAX   = 3'd7;

    localparam logic [31:0] LOST_DIST_SQ = 32'd1048576;
    localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
    localparam int CORDIC_STEPS = 16;

    // arctangent table, units of 2^-16 rad
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] r;
        begin
            case (i)
                4'd0:  r = 16'd51472;
                4'd1:  r = 16'd30386;
                4'd2:  r = 16'd16055;
                4'd3:  r = 16'd8150;
                4'd4:  r = 16'd4091;
                4'd5:  r = 16'd2047;
                4'd6:  r = 16'd1024;
                4'd7:  r = 16'd512;
                4'd8:  r = 16'd256;
                4'd9:  r = 16'd128;
                4'd10: r = 16'd64;
                4'd11: r = 16'd32;
                4'd12: r = 16'd16;
                4'd13: r = 16'd8;
                4'd14: r = 16'd4;
                default: r = 16'd2;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic [14:0] follow_distance;
        logic [14:0] linear_deadband;
        logic [11:0] angular_deadband;
        logic [15:0] linear_gain;
        logic [15:0] angular_gain;
        logic [14:0] lin_max;
        logic [14:0] lin_min;
        logic [14:0] turn_max;
    } cfg_t;

endpackage

// ----- src/nearest_target_follow_controller_top.sv -----
// Top level of the nearest-target follow controller.
// s_axis carries one request per item, kind in tuser: centroid, end of
//  frame or set tracking mode. Centroids keep the one nearest the origin
//  (not tracking) or nearest the stored target (tracking). An end of frame
//  emits one result on m_axis: status, speed commands and stored target.
// cfg_we/cfg_index/cfg_data write one control register per cycle; write
//  only while the block is idle with no result pending.
// Sequencing, one shared 17x16 multiplier under a small sequencer:
//  - mode change and unused kind: taken in S_IDLE, which they do not leave.
//  - centroid: dx^2 (S_SQX), dy^2 (S_SQY), compare (S_CMP), then S_IDLE.
//  - end of frame without command: S_EOF, then S_OUT registers the result.
//  - end of frame with command: two squares, 16-step root with the CORDIC
//    bearing alongside, deadband check, then two gain multiplies unless
//    both errors are inside their deadbands; S_OUT registers the result.
// s_tready is low while a request is in work.
// Stall: the output register holds its result until m_tready; a following
//  result waits in the last state and no new request is taken meanwhile.
// Reset (aresetn low, synchronous): clears tracking, target and frame
//  state, drops m_tvalid and loads register defaults.
module nearest_target_follow_controller_top #(
    parameter int MIN_TURN_SPEED = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: point_x[15:0], point_y[31:16], tracking_on[32], zero fill
    input  logic [39:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: forward speed[15:0], turn rate[31:16], target_x[47:32],
    //        target_y[63:48]
    output logic [63:0] m_tdata,
    // tuser: status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SQX   = 10'b0000000010,
        S_SQY   = 10'b0000000100,
        S_CMP   = 10'b0000001000,
        S_EOF   = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_WAIT  = 10'b0001000000,
        S_LMUL  = 10'b0010000000,
        S_AMUL  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    ntfc_pkg::cfg_t cfg_reg;

    logic               tracking_reg, has_pt_reg, point_pass_reg;
    logic signed [15:0] tgt_x_reg, tgt_y_reg, best_x_reg, best_y_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [31:0] best_d_reg;
    logic [32:0] acc_reg;              // sum of squares, saturated to 33 bits
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] prod;
    logic [33:0] sq_sum;
    logic [31:0] d_sat;
    // square root
    logic [31:0] rem_reg;
    logic [15:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    // command shaping
    logic signed [16:0] err_reg;
    logic signed [15:0] theta_reg;
    logic signed [15:0] lin_reg, ang_reg;
    logic [1:0]         status_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic [1:0]         m_user_reg;
    logic               cor_start, cor_done;
    logic signed [15:0] cor_theta;
    logic [16:0] emag, tmag;
    logic [32:0] lm;

    localparam logic [14:0] MIN_TURN = 15'(MIN_TURN_SPEED);

    // shared multiplier: 17 x 16 unsigned, squares and gain products
    assign prod = {16'd0, mul_a} * {17'd0, mul_b};

    function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        begin
            d = 17'(a) - 17'(b);
            return d[16] ? 17'(-d) : 17'(d);
        end
    endfunction

    logic [16:0] dx_mag, dy_mag;
    always_comb begin
        if (state_reg == S_SQX || state_reg == S_SQY) begin
            if (point_pass_reg) begin
                dx_mag = absdiff(px_reg, tracking_reg ? tgt_x_reg : 16'sd0);
                dy_mag = absdiff(py_reg, tracking_reg ? tgt_y_reg : 16'sd0);
            end else begin
                dx_mag = absdiff(best_x_reg, 16'sd0);
                dy_mag = absdiff(best_y_reg, 16'sd0);
            end
        end else begin
            dx_mag = '0;
            dy_mag = '0;
        end
    end

    assign emag = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign tmag = theta_reg[15] ? 17'(-17'(theta_reg)) : 17'(theta_reg);

    // |d| is at most 65535, so bit 16 is always clear
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX: begin mul_a = dx_mag; mul_b = dx_mag[15:0]; end
            S_SQY: begin mul_a = dy_mag; mul_b = dy_mag[15:0]; end
            S_LMUL: begin mul_a = emag; mul_b = cfg_reg.linear_gain; end
            S_AMUL: begin mul_a = tmag; mul_b = cfg_reg.angular_gain; end
            default: begin end
        endcase
    end

    assign sq_sum = {1'b0, acc_reg} + {1'b0, prod};

    assign d_sat = (acc_reg[32]) ? 32'hFFFFFFFF : acc_reg[31:0];

    assign lm = prod >> 8;

    function automatic logic [14:0] clampm(input logic [32:0] v,
                                           input logic [14:0] vmax,
                                           input logic [14:0] vmin);
        logic [32:0] r;
        begin
            r = (v > 33'(vmax)) ? 33'(vmax) : v;
            if (r < 33'(vmin)) r = 33'(vmin);
            return r[14:0];
        end
    endfunction

    assign cor_start = (state_reg == S_EOF) && has_pt_reg && tracking_reg &&
                       (best_d_reg <= ntfc_pkg::LOST_DIST_SQ);

    ntfc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .px      (best_x_reg),
        .py      (best_y_reg),
        .done    (cor_done),
        .theta   (cor_theta)
    );

    logic cor_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tracking_reg <= 1'b0;
            has_pt_reg   <= 1'b0;
            best_d_reg   <= '1;
            best_x_reg   <= '0;
            best_y_reg   <= '0;
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_user_reg   <= '0;
            cor_seen_reg <= 1'b0;
            cfg_reg.follow_distance   <= 15'd1536;
            cfg_reg.linear_deadband   <= 15'd102;
            cfg_reg.angular_deadband  <= 12'd102;
            cfg_reg.linear_gain       <= 16'd256;
            cfg_reg.angular_gain      <= 16'd256;
            cfg_reg.lin_max           <= 15'd512;
            cfg_reg.lin_min           <= 15'd102;
            cfg_reg.turn_max          <= 15'd1024;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ntfc_pkg::REG_FOLLOW: cfg_reg.follow_distance <= cfg_data[14:0];
                    ntfc_pkg::REG_LDB:    cfg_reg.linear_deadband <= cfg_data[14:0];
                    ntfc_pkg::REG_ADB:    cfg_reg.angular_deadband <= cfg_data[11:0];
                    ntfc_pkg::REG_LGAIN:  cfg_reg.linear_gain <= cfg_data;
                    ntfc_pkg::REG_AGAIN:  cfg_reg.angular_gain <= cfg_data;
                    ntfc_pkg::REG_LMAX:   cfg_reg.lin_max <= cfg_data[14:0];
                    ntfc_pkg::REG_LMIN:   cfg_reg.lin_min <= cfg_data[14:0];
                    default:              cfg_reg.turn_max <= cfg_data[14:0];
                endcase
            end
            // S_OUT refills the output register itself
            if (m_valid_reg && m_tready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            if (cor_done) begin
                cor_seen_reg <= 1'b1;
                theta_reg    <= cor_theta;
            end

            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    case (s_tuser)
                        ntfc_pkg::KIND_POINT: begin
                            px_reg <= s_tdata[15:0];
                            py_reg <= s_tdata[31:16];
                            point_pass_reg <= 1'b1;
                            state_reg <= S_SQX;
                        end
                        ntfc_pkg::KIND_MODE: begin
                            tracking_reg <= s_tdata[32];
                            has_pt_reg <= 1'b0;
                            best_d_reg <= '1;
                            best_x_reg <= '0;
                            best_y_reg <= '0;
                        end
                        ntfc_pkg::KIND_EOF: state_reg <= S_EOF;
                        default: begin end
                    endcase
                end
                S_SQX: begin
                    acc_reg <= prod;
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    acc_reg <= sq_sum[33] ? 33'h1FFFFFFFF : sq_sum[32:0];
                    state_reg <= point_pass_reg ? S_CMP : S_SQRT;
                    sq_cnt_reg <= '0;
                    rem_reg <= '0;
                    root_reg <= '0;
                end
                S_CMP: begin
                    if (!has_pt_reg || d_sat < best_d_reg) begin
                        best_x_reg <= px_reg;
                        best_y_reg <= py_reg;
                        best_d_reg <= d_sat;
                    end
                    has_pt_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EOF: begin
                    lin_reg <= '0;
                    ang_reg <= '0;
                    cor_seen_reg <= 1'b0;
                    if (!has_pt_reg) begin
                        status_reg <= ntfc_pkg::ST_NONE;
                        state_reg <= S_OUT;
                    end else if (!tracking_reg) begin
                        tgt_x_reg <= best_x_reg;
                        tgt_y_reg <= best_y_reg;
                        status_reg <= ntfc_pkg::ST_CHOSEN;
                        state_reg <= S_OUT;
                    end else if (best_d_reg > ntfc_pkg::LOST_DIST_SQ) begin
                        status_reg <= ntfc_pkg::ST_LOST;
                        state_reg <= S_OUT;
                    end else begin
                        tgt_x_reg <= best_x_reg;
                        tgt_y_reg <= best_y_reg;
                        status_reg <= ntfc_pkg::ST_CMD;
                        point_pass_reg <= 1'b0;
                        state_reg <= S_SQX;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle on the (saturated) 32-bit value
                    if (sq_cnt_reg == 5'd16) begin
                        err_reg <= 17'($signed({1'b0, root_reg})) -
                                   17'($signed({2'b0, cfg_reg.follow_distance}));
                        state_reg <= S_WAIT;
                    end else begin
                        if ({rem_reg, d_sat[31:30]} >= {root_reg, 2'b01}) begin
                            rem_reg <= 32'({rem_reg, d_sat[31:30]} - {root_reg, 2'b01});
                            root_reg <= {root_reg[14:0], 1'b1};
                        end else begin
                            rem_reg <= 32'({rem_reg, d_sat[31:30]});
                            root_reg <= {root_reg[14:0], 1'b0};
                        end
                        acc_reg <= {1'b0, d_sat[29:0], 2'b00};
                        sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    end
                end
                S_WAIT: if (cor_seen_reg || cor_done) begin
                    if (emag > 17'(cfg_reg.linear_deadband) ||
                        tmag > 17'(cfg_reg.angular_deadband)) begin
                        state_reg <= S_LMUL;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_LMUL: begin
                    lin_reg <= err_reg[16] ?
                        -$signed({1'b0, clampm(lm, cfg_reg.lin_max,
                                               cfg_reg.lin_min)}) :
                        $signed({1'b0, clampm(lm, cfg_reg.lin_max,
                                              cfg_reg.lin_min)});
                    state_reg <= S_AMUL;
                end
                S_AMUL: begin
                    ang_reg <= theta_reg[15] ?
                        -$signed({1'b0, clampm(lm, cfg_reg.turn_max, MIN_TURN)}) :
                        $signed({1'b0, clampm(lm, cfg_reg.turn_max, MIN_TURN)});
                    state_reg <= S_OUT;
                end
                S_OUT: if (!m_valid_reg || m_tready) begin
                    m_valid_reg <= 1'b1;
                    m_data_reg <= {tgt_y_reg, tgt_x_reg, ang_reg, lin_reg};
                    m_user_reg <= status_reg;
                    has_pt_reg <= 1'b0;
                    best_d_reg <= '1;
                    best_x_reg <= '0;
                    best_y_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped under stall");
    a_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ntfc_pkg::ST_CMD) |-> (m_tdata[31:0] == 32'd0))
        else $error("speed on non-command status");
endmodule

// ----- src/ntfc_cordic.sv -----
// Iterative vectoring CORDIC: bearing of a Q5.10 point, rounded to Q5.10.
module ntfc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] px,
    input  logic signed [15:0] py,
    output logic               done,
    output logic signed [15:0] theta
);
    // x grows by gain ~1.65 and pre-rotation, 28 bits is ample
    logic signed [27:0] x_reg, y_reg;
    logic signed [23:0] z_reg;
    logic [3:0]  step_reg;
    logic        busy_reg, done_reg, zero_reg;
    logic signed [27:0] xs, ys, x0, y0;
    logic signed [23:0] at, z0;
    logic [23:0] zmag;
    logic [17:0] m;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = $signed({8'd0, ntfc_pkg::atan_q16(step_reg)});

    always_comb begin
        x0 = {{4{px[15]}}, px, 8'd0};
        y0 = {{4{py[15]}}, py, 8'd0};
        z0 = '0;
        if (px[15]) begin
            if (!py[15]) begin
                x0 = {{4{py[15]}}, py, 8'd0};
                y0 = -{{4{px[15]}}, px, 8'd0};
                z0 = ntfc_pkg::HALF_PI_Q16;
            end else begin
                x0 = -{{4{py[15]}}, py, 8'd0};
                y0 = {{4{px[15]}}, px, 8'd0};
                z0 = -ntfc_pkg::HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
                zero_reg <= (px == 16'sd0) && (py == 16'sd0);
            end else if (busy_reg) begin
                if (y_reg > 28'sd0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(ntfc_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign zmag = z_reg[23] ? 24'(-z_reg) : 24'(z_reg);
    assign m = 18'((zmag + 24'd32) >> 6);
    assign done = done_reg;
    assign theta = zero_reg ? 16'sd0 :
                   (z_reg[23] ? -$signed(m[15:0]) : $signed(m[15:0]));
endmodule
